FILE: rtl/tlg_pkg.sv
package tlg_pkg;

  // position and trig formats
  localparam int POS_WIDTH      = 16;
  localparam int TRIG_FRAC_BITS = 15;
  localparam int TRIG_W         = TRIG_FRAC_BITS + 2;   // signed, spans -2^F..2^F
  localparam int DIST_W         = 17;                   // signed distance, negation exact
  localparam int HEAD_W         = 9;
  localparam int CENTER_W       = 15;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = CENTER_W;

  localparam logic [HEAD_W-1:0]   DEG_QUARTER = HEAD_W'(90);
  localparam logic [HEAD_W-1:0]   DEG_HALF    = HEAD_W'(180);
  localparam logic [HEAD_W-1:0]   DEG_3QUART  = HEAD_W'(270);
  localparam logic [HEAD_W-1:0]   DEG_FULL    = HEAD_W'(360);

  localparam logic [CENTER_W-1:0] CENTER_X_RST = CENTER_W'(320);
  localparam logic [CENTER_W-1:0] CENTER_Y_RST = CENTER_W'(240);

  // pi in Q2.30
  localparam longint PI_Q30 = 64'sd3373259426;

  typedef enum logic [3:0] {
    OP_FWD       = 4'd0,
    OP_BACK      = 4'd1,
    OP_TURN_PLUS = 4'd2,
    OP_TURN_MIN  = 4'd3,
    OP_PEN_UP    = 4'd4,
    OP_PEN_DOWN  = 4'd5,
    OP_SET_RED   = 4'd6,
    OP_SET_GREEN = 4'd7,
    OP_SET_BLUE  = 4'd8,
    OP_RESTART   = 4'd9
  } tlg_op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X = 2'd0,
    REG_CENTER_Y = 2'd1
  } tlg_reg_t;

  typedef struct packed {
    logic [3:0]         op;
    logic signed [15:0] value;
  } tlg_in_t;

  typedef struct packed {
    logic signed [15:0] from_x;
    logic signed [15:0] from_y;
    logic signed [15:0] to_x;
    logic signed [15:0] to_y;
    logic [7:0]         seg_red;
    logic [7:0]         seg_green;
    logic [7:0]         seg_blue;
  } tlg_out_t;

  typedef logic [TRIG_FRAC_BITS:0] sin_tab_t [0:90];
  typedef logic [HEAD_W-1:0]       mod_tab_t [0:255];

  // quarter-wave sine table, series evaluation in Q30 then rounded to F bits
  function automatic sin_tab_t build_sin_tab();
    sin_tab_t tab;
    longint   x;
    longint   x2;
    longint   term;
    longint   sum;
    for (int k = 0; k <= 90; k++) begin
      x    = (longint'(k) * PI_Q30 + 64'sd90) / 180;
      x2   = (x * x) >>> 30;
      term = x;
      sum  = x;
      for (int n = 1; n <= 9; n++) begin
        term = (term * x2) >>> 30;
        case (n)
          1:       term = term / 6;
          2:       term = term / 20;
          3:       term = term / 42;
          4:       term = term / 72;
          5:       term = term / 110;
          6:       term = term / 156;
          7:       term = term / 210;
          8:       term = term / 272;
          default: term = term / 342;
        endcase
        if (n % 2 == 1) sum = sum - term;
        else            sum = sum + term;
      end
      if (sum < 0) sum = 0;
      tab[k] = (TRIG_FRAC_BITS+1)'((sum + (64'sd1 <<< (29 - TRIG_FRAC_BITS)))
                                   >>> (30 - TRIG_FRAC_BITS));
    end
    return tab;
  endfunction

  // (hi * 256) mod 360 for the signed high byte of a turn angle
  function automatic mod_tab_t build_mod_tab();
    mod_tab_t tab;
    int       hi;
    int       m;
    for (int k = 0; k < 256; k++) begin
      hi = (k >= 128) ? k - 256 : k;
      m  = (hi * 256) % 360;
      if (m < 0) m = m + 360;
      tab[k] = HEAD_W'(m);
    end
    return tab;
  endfunction

  localparam sin_tab_t SIN_TAB = build_sin_tab();
  localparam mod_tab_t MOD_TAB = build_mod_tab();

  // sine of a heading in 0..359 by quadrant symmetry
  function automatic logic signed [TRIG_W-1:0] sin_deg(input logic [HEAD_W-1:0] h);
    logic [1:0]              q;
    logic [HEAD_W-1:0]       r;
    logic [6:0]              idx;
    logic [TRIG_W-1:0]       mag;
    if (h >= DEG_3QUART) begin
      q = 2'd3; r = h - DEG_3QUART;
    end else if (h >= DEG_HALF) begin
      q = 2'd2; r = h - DEG_HALF;
    end else if (h >= DEG_QUARTER) begin
      q = 2'd1; r = h - DEG_QUARTER;
    end else begin
      q = 2'd0; r = h;
    end
    idx = q[0] ? 7'(DEG_QUARTER - r) : r[6:0];
    mag = {1'b0, SIN_TAB[idx]};
    return q[1] ? -signed'(mag) : signed'(mag);
  endfunction

endpackage

FILE: rtl/tlg_trig.sv
module tlg_trig
  import tlg_pkg::*;
(
  input  logic [HEAD_W-1:0]        heading,
  output logic signed [TRIG_W-1:0] cos_val,
  output logic signed [TRIG_W-1:0] sin_val
);

  logic [HEAD_W:0]   h90_sum;
  logic [HEAD_W-1:0] h90;

  // cos(h) = sin(h + 90), wrapped into 0..359
  assign h90_sum = {1'b0, heading} + {1'b0, DEG_QUARTER};
  assign h90     = (h90_sum >= {1'b0, DEG_FULL}) ? HEAD_W'(h90_sum - {1'b0, DEG_FULL})
                                                  : h90_sum[HEAD_W-1:0];

  assign cos_val = sin_deg(h90);
  assign sin_val = sin_deg(heading);

endmodule

FILE: rtl/tlg_turn.sv
module tlg_turn
  import tlg_pkg::*;
(
  input  logic [HEAD_W-1:0] heading,
  input  logic signed [15:0] angle,
  input  logic              minus,
  output logic [HEAD_W-1:0] heading_nxt
);

  logic [HEAD_W:0]   part_sum;
  logic [HEAD_W-1:0] ang_mod;
  logic [HEAD_W:0]   plus_sum;

  // angle mod 360: high byte by table, low byte added, one correction
  assign part_sum = {1'b0, MOD_TAB[angle[15:8]]} + {2'b0, angle[7:0]};
  assign ang_mod  = (part_sum >= {1'b0, DEG_FULL}) ? HEAD_W'(part_sum - {1'b0, DEG_FULL})
                                                    : part_sum[HEAD_W-1:0];

  assign plus_sum = {1'b0, heading} + {1'b0, ang_mod};

  always_comb begin
    if (minus) begin
      heading_nxt = (heading >= ang_mod) ? heading - ang_mod
                                         : HEAD_W'(heading + DEG_FULL - ang_mod);
    end else begin
      heading_nxt = (plus_sum >= {1'b0, DEG_FULL}) ? HEAD_W'(plus_sum - {1'b0, DEG_FULL})
                                                    : plus_sum[HEAD_W-1:0];
    end
  end

endmodule

FILE: rtl/tlg_step.sv
module tlg_step
  import tlg_pkg::*;
(
  input  logic [POS_WIDTH-1:0]     pos_in,
  input  logic signed [DIST_W-1:0] travel,
  input  logic signed [TRIG_W-1:0] trig,
  output logic [POS_WIDTH-1:0]     pos_out
);

  localparam int PROD_W = DIST_W + TRIG_W;
  localparam int ACC_W  = POS_WIDTH + TRIG_FRAC_BITS + PROD_W + 1;

  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  pos_ext;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  quo;
  logic                     round_up;
  logic signed [ACC_W-1:0]  quo_adj;

  assign prod    = travel * trig;
  assign pos_ext = ACC_W'(signed'(pos_in));
  assign acc     = (pos_ext <<< TRIG_FRAC_BITS) + ACC_W'(prod);

  // arithmetic shift floors; bump negative inexact results toward zero
  assign quo      = acc >>> TRIG_FRAC_BITS;
  assign round_up = acc[ACC_W-1] && (|acc[TRIG_FRAC_BITS-1:0]);
  assign quo_adj  = quo + ACC_W'({1'b0, round_up});
  assign pos_out  = quo_adj[POS_WIDTH-1:0];

endmodule

FILE: rtl/turtle_line_generator_core.sv
// turtle line generator: executes turtle drawing commands, one per transaction
//
// input channel (in_valid / in_ready / in_data): one command per transaction,
//   op selects move forward/back, turn, pen up/down, colour set or restart
// result channel (out_valid / out_ready / out_data): one line segment for every
//   move made with the pen down, nothing for any other command
// config port (cfg_we / cfg_index / cfg_wdata): start position centre_x/centre_y,
//   takes effect at the next restart command; reset restores (320, 240)
//
// execution: a command accepted into the input register is executed from there,
//   and its segment is written into the result register
// throughput: one command per cycle while the result register is free or draining,
//   set by the single execute stage that updates position, heading, pen and colour
// stalls: while out_ready is low and a segment is held, the execute stage waits
//   and the input register fills, then in_ready drops; no transaction is lost
// reset: position goes to the reset centre (320, 240), heading zero, pen down,
//   colour black, both channels empty
module turtle_line_generator_core
  import tlg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  output logic                  in_ready,
  input  tlg_in_t               in_data,

  output logic                  out_valid,
  input  logic                  out_ready,
  output tlg_out_t              out_data,

  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // input register
  logic    s1_valid_r, s1_valid_nxt;
  tlg_in_t s1_item_r;

  // result register
  logic     out_valid_r, out_valid_nxt;
  tlg_out_t out_item_r, out_item_nxt;

  // turtle state
  logic [POS_WIDTH-1:0] pos_x_r, pos_x_nxt;
  logic [POS_WIDTH-1:0] pos_y_r, pos_y_nxt;
  logic [HEAD_W-1:0]    heading_r, heading_nxt;
  logic                 pen_down_r, pen_down_nxt;
  logic [7:0]           red_r, red_nxt;
  logic [7:0]           green_r, green_nxt;
  logic [7:0]           blue_r, blue_nxt;

  // configuration
  logic [CENTER_W-1:0]  center_x_r, center_y_r;

  logic                     exec_fire;
  logic                     emit;
  logic signed [DIST_W-1:0] value_ext;
  logic signed [DIST_W-1:0] travel;
  logic signed [TRIG_W-1:0] cos_val, sin_val;
  logic [POS_WIDTH-1:0]     move_x, move_y;
  logic [HEAD_W-1:0]        turn_heading;

  // execute when a command waits and the result register is free or draining
  assign exec_fire = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || exec_fire;

  // back moves negate the distance at full width so the most negative value is exact
  assign value_ext = DIST_W'(s1_item_r.value);
  assign travel    = (s1_item_r.op == OP_BACK) ? -value_ext : value_ext;

  tlg_trig u_trig (
    .heading (heading_r),
    .cos_val (cos_val),
    .sin_val (sin_val)
  );

  tlg_step u_step_x (
    .pos_in  (pos_x_r),
    .travel  (travel),
    .trig    (cos_val),
    .pos_out (move_x)
  );

  tlg_step u_step_y (
    .pos_in  (pos_y_r),
    .travel  (travel),
    .trig    (sin_val),
    .pos_out (move_y)
  );

  tlg_turn u_turn (
    .heading     (heading_r),
    .angle       (s1_item_r.value),
    .minus       (s1_item_r.op == OP_TURN_MIN),
    .heading_nxt (turn_heading)
  );

  // command decode and state update
  always_comb begin
    pos_x_nxt    = pos_x_r;
    pos_y_nxt    = pos_y_r;
    heading_nxt  = heading_r;
    pen_down_nxt = pen_down_r;
    red_nxt      = red_r;
    green_nxt    = green_r;
    blue_nxt     = blue_r;
    emit         = 1'b0;
    if (exec_fire) begin
      unique case (s1_item_r.op)
        OP_FWD, OP_BACK: begin
          pos_x_nxt = move_x;
          pos_y_nxt = move_y;
          emit      = pen_down_r;
        end
        OP_TURN_PLUS, OP_TURN_MIN: heading_nxt  = turn_heading;
        OP_PEN_UP:                 pen_down_nxt = 1'b0;
        OP_PEN_DOWN:               pen_down_nxt = 1'b1;
        OP_SET_RED:                red_nxt      = s1_item_r.value[7:0];
        OP_SET_GREEN:              green_nxt    = s1_item_r.value[7:0];
        OP_SET_BLUE:               blue_nxt     = s1_item_r.value[7:0];
        OP_RESTART: begin
          pos_x_nxt    = POS_WIDTH'(center_x_r);
          pos_y_nxt    = POS_WIDTH'(center_y_r);
          heading_nxt  = '0;
          pen_down_nxt = 1'b1;
          red_nxt      = '0;
          green_nxt    = '0;
          blue_nxt     = '0;
        end
        default: ;  // unused opcodes are no-ops
      endcase
    end
  end

  // segment payload, taken from the state before the move
  always_comb begin
    out_item_nxt.from_x    = 16'(pos_x_r);
    out_item_nxt.from_y    = 16'(pos_y_r);
    out_item_nxt.to_x      = 16'(move_x);
    out_item_nxt.to_y      = 16'(move_y);
    out_item_nxt.seg_red   = red_r;
    out_item_nxt.seg_green = green_r;
    out_item_nxt.seg_blue  = blue_r;
  end

  always_comb begin
    if (emit)           out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else                out_valid_nxt = out_valid_r;
  end

  assign s1_valid_nxt = in_ready ? in_valid : s1_valid_r;

  // control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pos_x_r     <= POS_WIDTH'(CENTER_X_RST);
      pos_y_r     <= POS_WIDTH'(CENTER_Y_RST);
      heading_r   <= '0;
      pen_down_r  <= 1'b1;
      red_r       <= '0;
      green_r     <= '0;
      blue_r      <= '0;
      center_x_r  <= CENTER_X_RST;
      center_y_r  <= CENTER_Y_RST;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      pos_x_r     <= pos_x_nxt;
      pos_y_r     <= pos_y_nxt;
      heading_r   <= heading_nxt;
      pen_down_r  <= pen_down_nxt;
      red_r       <= red_nxt;
      green_r     <= green_nxt;
      blue_r      <= blue_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_CENTER_X: center_x_r <= cfg_wdata;
          REG_CENTER_Y: center_y_r <= cfg_wdata;
          default: ;  // writes beyond the register list are dropped
        endcase
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_data;
    end
    if (emit) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  // heading always kept in 0..359
  a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
    heading_r < DEG_FULL)
    else $error("heading out of range");

  // a segment only appears after the execute stage has fired
  a_out_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(exec_fire))
    else $error("result appeared without an executed command");

  // a command that draws nothing must not leave a segment behind once drained
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    exec_fire && !emit && out_ready |=> !out_valid)
    else $error("segment emitted for a non-drawing command");

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import tlg_pkg::*;

  // spare codes that the block must ignore
  localparam logic [3:0]           OP_SPARE_LO = 4'd10;
  localparam logic [3:0]           OP_SPARE_HI = 4'd15;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
  localparam logic [CENTER_W-1:0]  CENTER_MAX  = '1;

  localparam int CHUNK_COUNT = 8;
  localparam int CHUNK_CMDS  = 180;
  localparam int SETTLE_CYCLES = 8;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  tlg_in_t               in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  tlg_out_t              out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // stimulus and scoreboard
  tlg_in_t  pending_cmds[$];
  tlg_out_t expected_segments[$];
  int       cmds_issued = 0;
  int       cmds_accepted = 0;
  int       error_count = 0;
  logic     cmd_taken = 1'b0;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;

  // turtle state as the block should hold it
  logic [15:0]         turtle_x;
  logic [15:0]         turtle_y;
  int                  heading_deg;
  logic                pen_is_down;
  logic [7:0]          ink_red;
  logic [7:0]          ink_green;
  logic [7:0]          ink_blue;
  logic [CENTER_W-1:0] start_x = CENTER_X_RST;
  logic [CENTER_W-1:0] start_y = CENTER_Y_RST;
  longint              quarter_sine [0:90];

  turtle_line_generator_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // sine of 0..90 degrees: taylor series in q30, rounded to the trig fraction width
  initial begin : build_quarter_sine
    longint x;
    longint x2;
    longint term;
    longint sum;
    for (int k = 0; k <= 90; k++) begin
      x    = (longint'(k) * PI_Q30 + 90) / 180;
      x2   = (x * x) >>> 30;
      term = x;
      sum  = x;
      for (int n = 1; n <= 9; n++) begin
        term = ((term * x2) >>> 30) / longint'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) sum = sum - term;
        else            sum = sum + term;
      end
      if (sum < 0) sum = 0;
      quarter_sine[k] = (sum + (longint'(1) << (29 - TRIG_FRAC_BITS))) >>>
                        (30 - TRIG_FRAC_BITS);
    end
  end

  // full-circle sine by quadrant symmetry, heading in 0..359
  function automatic longint sine_of(int deg);
    int     quad;
    int     rem;
    longint mag;
    quad = (deg / 90) & 3;
    rem  = deg % 90;
    mag  = quad[0] ? quarter_sine[90 - rem] : quarter_sine[rem];
    return quad[1] ? -mag : mag;
  endfunction

  // one axis of a move: truncate toward zero, then wrap to 16 bits
  function automatic logic [15:0] step_axis(logic signed [15:0] p, longint travel,
                                            longint trig);
    longint acc;
    acc = longint'(p) * (longint'(1) << TRIG_FRAC_BITS) + travel * trig;
    acc = acc / (longint'(1) << TRIG_FRAC_BITS);
    return acc[15:0];
  endfunction

  function automatic void restart_turtle();
    turtle_x    = {1'b0, start_x};
    turtle_y    = {1'b0, start_y};
    heading_deg = 0;
    pen_is_down = 1'b1;
    ink_red     = '0;
    ink_green   = '0;
    ink_blue    = '0;
  endfunction

  // apply one accepted command to the turtle, queueing the segment it draws
  function automatic void execute_turtle_cmd(tlg_in_t cmd);
    longint      travel;
    logic [15:0] nx;
    logic [15:0] ny;
    int          turned;
    tlg_out_t    seg;
    case (cmd.op)
      OP_FWD, OP_BACK: begin
        // negation done wide so a back move of -32768 is exact
        travel = (cmd.op == OP_FWD) ? longint'(cmd.value) : -longint'(cmd.value);
        nx = step_axis(turtle_x, travel, sine_of((heading_deg + 90) % 360));
        ny = step_axis(turtle_y, travel, sine_of(heading_deg));
        if (pen_is_down) begin
          seg.from_x    = turtle_x;
          seg.from_y    = turtle_y;
          seg.to_x      = nx;
          seg.to_y      = ny;
          seg.seg_red   = ink_red;
          seg.seg_green = ink_green;
          seg.seg_blue  = ink_blue;
          expected_segments = {expected_segments, seg};
        end
        turtle_x = nx;
        turtle_y = ny;
      end
      OP_TURN_PLUS, OP_TURN_MIN: begin
        turned = heading_deg +
                 ((cmd.op == OP_TURN_PLUS) ? int'(cmd.value) : -int'(cmd.value));
        turned = turned % 360;
        if (turned < 0) turned = turned + 360;
        heading_deg = turned;
      end
      OP_PEN_UP:    pen_is_down = 1'b0;
      OP_PEN_DOWN:  pen_is_down = 1'b1;
      OP_SET_RED:   ink_red   = cmd.value[7:0];
      OP_SET_GREEN: ink_green = cmd.value[7:0];
      OP_SET_BLUE:  ink_blue  = cmd.value[7:0];
      OP_RESTART:   restart_turtle();
      default: ;    // spare opcodes leave everything alone
    endcase
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h got %h", $time, name, want, got);
      error_count++;
    end
  endtask

  // driver: a new command goes out once the previous transaction has completed
  always @(negedge clk) begin
    if (!in_valid || cmd_taken) begin
      if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= pending_cmds.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // monitor: checks each segment transaction, then predicts from each command transaction
  always @(posedge clk) begin
    tlg_out_t want;
    if (!rst_n) begin
      restart_turtle();
      cmd_taken <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_segments.size() == 0) begin
          $display("%0t: segment with none expected, expected nothing got %h",
                   $time, out_data);
          error_count++;
        end else begin
          want = expected_segments.pop_front();
          check_field("from_x",    want.from_x,    out_data.from_x);
          check_field("from_y",    want.from_y,    out_data.from_y);
          check_field("to_x",      want.to_x,      out_data.to_x);
          check_field("to_y",      want.to_y,      out_data.to_y);
          check_field("seg_red",   want.seg_red,   out_data.seg_red);
          check_field("seg_green", want.seg_green, out_data.seg_green);
          check_field("seg_blue",  want.seg_blue,  out_data.seg_blue);
        end
      end
      cmd_taken <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        execute_turtle_cmd(in_data);
        cmds_accepted++;
      end
    end
  end

  task automatic queue_cmd(input logic [3:0] op, input logic [15:0] value);
    tlg_in_t cmd;
    cmd.op    = op;
    cmd.value = value;
    pending_cmds = {pending_cmds, cmd};
    cmds_issued++;
  endtask

  // wait for every command to be taken and every segment to arrive, then let
  // the pipeline empty of commands that draw nothing
  task automatic wait_idle();
    while (cmds_accepted != cmds_issued || expected_segments.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      REG_CENTER_X: start_x = value;
      REG_CENTER_Y: start_y = value;
      default: ;    // spare indexes are dropped by the block
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // mostly moves with the pen down so segments are plentiful
  function automatic tlg_in_t random_cmd();
    tlg_in_t cmd;
    int      pick;
    pick      = $urandom_range(99);
    cmd.value = 16'($urandom());
    if (pick < 51) begin
      cmd.op = (pick < 35) ? OP_FWD : OP_BACK;
      if ($urandom_range(1)) cmd.value = 16'(int'($urandom_range(400)) - 200);
    end else if (pick < 71) begin
      cmd.op = (pick < 61) ? OP_TURN_PLUS : OP_TURN_MIN;
      if ($urandom_range(1)) cmd.value = 16'($urandom_range(359));
    end else if (pick < 75) cmd.op = OP_PEN_UP;
    else if (pick < 82) cmd.op = OP_PEN_DOWN;
    else if (pick < 86) cmd.op = OP_SET_RED;
    else if (pick < 90) cmd.op = OP_SET_GREEN;
    else if (pick < 94) cmd.op = OP_SET_BLUE;
    else if (pick < 97) cmd.op = OP_RESTART;
    else                cmd.op = 4'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
    return cmd;
  endfunction

  initial begin
    int cx;
    int cy;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // directed: field extremes, every opcode, turn wrap both ways, pen up moves
    send_idle_pct  = 16;
    recv_stall_pct = 16;
    queue_cmd(OP_FWD,       16'sd0);
    queue_cmd(OP_FWD,       16'sd32767);      // x wraps past the top
    queue_cmd(OP_BACK,      16'h8000);        // back by -32768 moves +32768
    queue_cmd(OP_SET_RED,   16'hFFFF);        // only low byte kept
    queue_cmd(OP_SET_GREEN, 16'h5A80);
    queue_cmd(OP_SET_BLUE,  16'h7F01);
    queue_cmd(OP_TURN_PLUS, 16'sd90);
    queue_cmd(OP_FWD,       16'h8000);
    queue_cmd(OP_TURN_MIN,  -16'sd45);        // heading 135
    queue_cmd(OP_BACK,      16'sd1000);
    queue_cmd(OP_TURN_PLUS, 16'sd32767);
    queue_cmd(OP_FWD,       16'sd123);
    queue_cmd(OP_TURN_MIN,  16'h8000);
    queue_cmd(OP_FWD,       16'sd77);
    queue_cmd(OP_TURN_MIN,  16'sd400);        // goes negative before mod
    queue_cmd(OP_FWD,       16'sd250);
    queue_cmd(OP_PEN_UP,    16'h0000);
    queue_cmd(OP_FWD,       16'sd500);        // moves without drawing
    queue_cmd(OP_BACK,      16'sd3);
    queue_cmd(OP_PEN_DOWN,  16'hFFFF);
    queue_cmd(OP_BACK,      16'sd32767);
    queue_cmd(OP_SPARE_LO,  16'h7FFF);
    queue_cmd(OP_SPARE_HI,  16'h8000);
    queue_cmd(OP_RESTART,   16'h1234);
    queue_cmd(OP_FWD,       16'sd1);

    // random chunks, each with its own centre setting and idling pattern
    for (int chunk = 0; chunk < CHUNK_COUNT; chunk++) begin
      wait_idle();
      if (chunk < 4) begin
        cx = (chunk == 1 || chunk == 2) ? int'(CENTER_MAX) : 0;
        cy = (chunk == 0 || chunk == 2) ? int'(CENTER_MAX) : 0;
      end else begin
        cx = $urandom_range(CENTER_MAX);
        cy = $urandom_range(CENTER_MAX);
      end
      write_reg(REG_CENTER_X, CENTER_W'(cx));
      write_reg(REG_CENTER_Y, CENTER_W'(cy));
      if (chunk % 2 == 1) begin
        // odd chunks carry on from the old position: new centres wait for a restart
        write_reg(REG_SPARE_A, CFG_DATA_W'($urandom()));
        write_reg(REG_SPARE_B, CFG_DATA_W'($urandom()));
      end else begin
        queue_cmd(OP_RESTART, 16'($urandom()));
      end
      case (chunk % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      for (int i = 0; i < CHUNK_CMDS; i++)
        pending_cmds = {pending_cmds, random_cmd()};
      cmds_issued += CHUNK_CMDS;
    end

    wait_idle();
    if (error_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  // watchdog
  initial begin
    #3_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

FILE: sim.f
rtl/tlg_pkg.sv
rtl/tlg_trig.sv
rtl/tlg_turn.sv
rtl/tlg_step.sv
rtl/turtle_line_generator_core.sv
test/tb_top.sv
